FILE: src/assert_macros.svh
// Assertion macros shared by the ready-queue scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/prqs_pkg.sv
// Types, codes and helpers shared by the ready-queue scheduler modules.
package prqs_pkg;

    // Wide enough for any slot or priority index in the supported range.
    localparam int ID_W = 6;

    typedef logic [ID_W-1:0] t_id;

    typedef enum logic [2:0] {
        A_CREATE  = 3'd0,
        A_EXIT    = 3'd1,
        A_READY   = 3'd2,
        A_UNREADY = 3'd3,
        A_SETP    = 3'd4,
        A_SCHED   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_NO_SLOT    = 3'd2,
        ST_NONE_READY = 3'd3,
        ST_NOT_HEAD   = 3'd4,
        ST_UNUSED     = 3'd5,
        ST_READY      = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_PRIO_RD,
        S_QRD,
        S_APPEND,
        S_UNRDY,
        S_WALK,
        S_CMP,
        S_LINK_RD,
        S_EXIT_CLR,
        S_SCHED_OUT,
        S_DONE
    } t_state;

    // Thread table request: flag set/clear and the priority write act on tid.
    typedef struct packed {
        t_id  tid;
        t_id  rd_addr;
        logic prio_we;
        t_id  prio_data;
        logic link_we;
        t_id  link_addr;
        t_id  link_data;
        logic link_vld;
        logic use_set;
        logic use_clr;
        logic rdy_set;
        logic rdy_clr;
        logic nv_clr;
    } t_thr_cmd;

    typedef struct packed {
        logic use_tid;
        logic rdy_tid;
        logic use_rd;
        t_id  prio_q;
        t_id  link_q;
        logic link_vld_q;
    } t_thr_sts;

    // Queue table request: head and tail are always addressed together.
    typedef struct packed {
        t_id  addr;
        logic head_we;
        t_id  head_data;
        logic head_vld;
        logic tail_we;
        t_id  tail_data;
        logic tail_vld;
    } t_q_cmd;

    typedef struct packed {
        logic head_v;
        logic tail_v;
        t_id  head_q;
        t_id  tail_q;
    } t_q_sts;

    typedef struct packed {
        t_status status;
        t_id     tout;
        t_id     oldp;
    } t_result;

    // Negative means keep (maps to 0); saturate at the last priority.
    function automatic t_id f_clamp(logic signed [4:0] p, t_id last);
        t_id v;
        v = t_id'(p[3:0]);
        if (p[4]) begin
            return '0;
        end
        if (v > last) begin
            return last;
        end
        return v;
    endfunction

endpackage

FILE: src/priority_ready_queue_scheduler.sv
// Top level of the fixed-priority FIFO ready-queue scheduler.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+-----------------------------------------
//   input   | i_in_valid   | o_in_stall   | i_action, i_thread_id, i_priority_req
//   output  | o_out_valid  | i_out_stall  | o_status, o_thread_out, o_old_priority
//
// One item at a time; o_in_stall is high from acceptance until its result is registered.
// Create scans slot flags one per cycle, schedule scans queue valid bits one per cycle,
// and exit walks its queue one link at a time.
// Reset clears all flags and queue valid bits directly; no clearing pass.
// A result held on a stalled output does not block the next accepted item until it is done.
module priority_ready_queue_scheduler #(
    parameter int THREADS    = 8,
    parameter int PRIORITIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_action,
    input  logic [2:0]        i_thread_id,
    input  logic signed [4:0] i_priority_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_status,
    output logic [2:0]        o_thread_out,
    output logic [3:0]        o_old_priority
);
    import prqs_pkg::*;

    t_thr_cmd w_thr_cmd;
    t_thr_sts w_thr_sts;
    t_q_cmd   w_q_cmd;
    t_q_sts   w_q_sts;
    t_result  w_res;
    logic     w_res_valid;
    logic     w_res_take;
    logic     w_busy;

    logic       r_ovalid;
    logic [2:0] r_status;
    logic [2:0] r_tout;
    logic [3:0] r_oldp;

    prqs_seq #(
        .THREADS    (THREADS),
        .PRIORITIES (PRIORITIES)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_busy         (w_busy),
        .i_action       (i_action),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .o_thr_cmd      (w_thr_cmd),
        .i_thr_sts      (w_thr_sts),
        .o_q_cmd        (w_q_cmd),
        .i_q_sts        (w_q_sts),
        .o_res_valid    (w_res_valid),
        .i_res_take     (w_res_take),
        .o_res          (w_res)
    );

    prqs_thread_tbl #(
        .THREADS    (THREADS),
        .PRIORITIES (PRIORITIES)
    ) u_thread_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_thr_cmd),
        .o_sts   (w_thr_sts)
    );

    prqs_queue_tbl #(
        .THREADS    (THREADS),
        .PRIORITIES (PRIORITIES)
    ) u_queue_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_q_cmd),
        .o_sts   (w_q_sts)
    );

    // Output register frees when empty or when its item is taken this cycle.
    assign w_res_take = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_take) begin
            r_ovalid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take && w_res_valid) begin
            r_status <= w_res.status;
            r_tout   <= w_res.tout[2:0];
            r_oldp   <= w_res.oldp[3:0];
        end
    end

    assign o_in_stall     = w_busy;
    assign o_out_valid    = r_ovalid;
    assign o_status       = r_status;
    assign o_thread_out   = r_tout;
    assign o_old_priority = r_oldp;

endmodule

FILE: src/prqs_thread_tbl.sv
// Thread slot table: in-use, ready and link-valid flags plus priority and link memories.
`include "assert_macros.svh"

module prqs_thread_tbl #(
    parameter int THREADS    = 8,
    parameter int PRIORITIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prqs_pkg::t_thr_cmd i_cmd,
    output prqs_pkg::t_thr_sts o_sts
);
    import prqs_pkg::*;

    localparam int TW = $clog2(THREADS);
    localparam int PW = $clog2(PRIORITIES);

    logic [THREADS-1:0] r_in_use;
    logic [THREADS-1:0] r_ready;
    logic [THREADS-1:0] r_nvld;

    logic [PW-1:0] r_prio_mem [THREADS];
    logic [TW-1:0] r_link_mem [THREADS];
    logic [PW-1:0] r_prio_rd;
    logic [TW-1:0] r_link_rd;
    logic          r_nvld_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_ready  <= '0;
            r_nvld   <= '0;
        end else begin
            if (i_cmd.use_set) r_in_use[i_cmd.tid[TW-1:0]] <= 1'b1;
            if (i_cmd.use_clr) r_in_use[i_cmd.tid[TW-1:0]] <= 1'b0;
            if (i_cmd.rdy_set) r_ready[i_cmd.tid[TW-1:0]] <= 1'b1;
            if (i_cmd.rdy_clr) r_ready[i_cmd.tid[TW-1:0]] <= 1'b0;
            if (i_cmd.link_we) r_nvld[i_cmd.link_addr[TW-1:0]] <= i_cmd.link_vld;
            // a cleared own link wins over a link write in the same cycle
            if (i_cmd.nv_clr)  r_nvld[i_cmd.tid[TW-1:0]] <= 1'b0;
        end
    end

    // Priority of a free slot is never read before create writes it: no clearing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prio_we) r_prio_mem[i_cmd.tid[TW-1:0]] <= i_cmd.prio_data[PW-1:0];
        if (i_cmd.link_we) r_link_mem[i_cmd.link_addr[TW-1:0]] <= i_cmd.link_data[TW-1:0];
        r_prio_rd <= r_prio_mem[i_cmd.rd_addr[TW-1:0]];
        r_link_rd <= r_link_mem[i_cmd.rd_addr[TW-1:0]];
        r_nvld_rd <= r_nvld[i_cmd.rd_addr[TW-1:0]];
    end

    assign o_sts.use_tid    = r_in_use[i_cmd.tid[TW-1:0]];
    assign o_sts.rdy_tid    = r_ready[i_cmd.tid[TW-1:0]];
    assign o_sts.use_rd     = r_in_use[i_cmd.rd_addr[TW-1:0]];
    assign o_sts.prio_q     = t_id'(r_prio_rd);
    assign o_sts.link_q     = t_id'(r_link_rd);
    assign o_sts.link_vld_q = r_nvld_rd;

    `ASSERT_IMPL(a_ready_in_use, i_clk, i_rst_n, 1'b1, (r_ready & ~r_in_use) == '0, "ready slot not in use")
    `ASSERT_IMPL(a_link_ready, i_clk, i_rst_n, 1'b1, (r_nvld & ~r_ready) == '0, "link on idle slot")

endmodule

FILE: src/prqs_queue_tbl.sv
// Per-priority FIFO head and tail pointers with their valid bits.
`include "assert_macros.svh"

module prqs_queue_tbl #(
    parameter int THREADS    = 8,
    parameter int PRIORITIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prqs_pkg::t_q_cmd i_cmd,
    output prqs_pkg::t_q_sts o_sts
);
    import prqs_pkg::*;

    localparam int TW = $clog2(THREADS);
    localparam int PW = $clog2(PRIORITIES);

    logic [PRIORITIES-1:0] r_head_v;
    logic [PRIORITIES-1:0] r_tail_v;

    logic [TW-1:0] r_head_mem [PRIORITIES];
    logic [TW-1:0] r_tail_mem [PRIORITIES];
    logic [TW-1:0] r_head_rd;
    logic [TW-1:0] r_tail_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= '0;
            r_tail_v <= '0;
        end else begin
            if (i_cmd.head_we) r_head_v[i_cmd.addr[PW-1:0]] <= i_cmd.head_vld;
            if (i_cmd.tail_we) r_tail_v[i_cmd.addr[PW-1:0]] <= i_cmd.tail_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_we) r_head_mem[i_cmd.addr[PW-1:0]] <= i_cmd.head_data[TW-1:0];
        if (i_cmd.tail_we) r_tail_mem[i_cmd.addr[PW-1:0]] <= i_cmd.tail_data[TW-1:0];
        r_head_rd <= r_head_mem[i_cmd.addr[PW-1:0]];
        r_tail_rd <= r_tail_mem[i_cmd.addr[PW-1:0]];
    end

    assign o_sts.head_v = r_head_v[i_cmd.addr[PW-1:0]];
    assign o_sts.tail_v = r_tail_v[i_cmd.addr[PW-1:0]];
    assign o_sts.head_q = t_id'(r_head_rd);
    assign o_sts.tail_q = t_id'(r_tail_rd);

    `ASSERT_IMPL(a_head_tail_pair, i_clk, i_rst_n, 1'b1, r_head_v == r_tail_v, "head/tail valid mismatch")

endmodule

FILE: src/prqs_seq.sv
// Action sequencer with the shared scan/walk index that steps through slots, queues and links.
`include "assert_macros.svh"

module prqs_seq #(
    parameter int THREADS    = 8,
    parameter int PRIORITIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_busy,
    input  logic [2:0]         i_action,
    input  logic [2:0]         i_thread_id,
    input  logic signed [4:0]  i_priority_req,
    output prqs_pkg::t_thr_cmd o_thr_cmd,
    input  prqs_pkg::t_thr_sts i_thr_sts,
    output prqs_pkg::t_q_cmd   o_q_cmd,
    input  prqs_pkg::t_q_sts   i_q_sts,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output prqs_pkg::t_result  o_res
);
    import prqs_pkg::*;

    localparam t_id LAST_T = t_id'(THREADS - 1);
    localparam t_id LAST_P = t_id'(PRIORITIES - 1);

    t_state           r_state, n_state;
    t_action          r_act, n_act;
    t_id              r_tid, n_tid;
    logic             r_tvalid, n_tvalid;
    logic signed [4:0] r_preq, n_preq;
    t_id              r_idx, n_idx;
    t_id              r_q, n_q;
    t_id              r_cur, n_cur;
    t_id              r_prev, n_prev;
    logic             r_have_prev, n_have_prev;
    t_id              r_tnext, n_tnext;
    logic             r_tnvld, n_tnvld;
    t_status          r_status, n_status;
    t_id              r_tout, n_tout;
    t_id              r_oldp, n_oldp;

    logic w_used;
    logic w_in_range;

    assign w_used     = r_tvalid && i_thr_sts.use_tid;
    assign w_in_range = int'(i_thread_id) < THREADS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_tid       <= n_tid;
        r_tvalid    <= n_tvalid;
        r_preq      <= n_preq;
        r_idx       <= n_idx;
        r_q         <= n_q;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_tnext     <= n_tnext;
        r_tnvld     <= n_tnvld;
        r_status    <= n_status;
        r_tout      <= n_tout;
        r_oldp      <= n_oldp;
    end

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_tid       = r_tid;
        n_tvalid    = r_tvalid;
        n_preq      = r_preq;
        n_idx       = r_idx;
        n_q         = r_q;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_tnext     = r_tnext;
        n_tnvld     = r_tnvld;
        n_status    = r_status;
        n_tout      = r_tout;
        n_oldp      = r_oldp;

        o_thr_cmd         = '0;
        o_thr_cmd.tid     = r_tid;
        o_thr_cmd.rd_addr = r_tid;
        o_q_cmd           = '0;
        o_q_cmd.addr      = r_q;
        o_res_valid       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = t_action'(i_action);
                    n_tid    = w_in_range ? t_id'(i_thread_id) : '0;
                    n_tvalid = w_in_range;
                    n_preq   = i_priority_req;
                    n_status = ST_OK;
                    n_tout   = '0;
                    n_oldp   = '0;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx = '0;
                case (r_act)
                    A_CREATE: begin
                        n_state = S_SCAN;
                    end
                    A_SCHED: begin
                        n_state = S_SCAN;
                    end
                    A_EXIT: begin
                        if (!w_used) begin
                            n_status = ST_UNUSED;
                            n_state  = S_DONE;
                        end else if (i_thr_sts.rdy_tid) begin
                            n_state = S_PRIO_RD;
                        end else begin
                            n_state = S_EXIT_CLR;
                        end
                    end
                    A_READY: begin
                        if (!w_used) begin
                            n_status = ST_UNUSED;
                            n_state  = S_DONE;
                        end else if (i_thr_sts.rdy_tid) begin
                            n_status = ST_IGNORED;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_PRIO_RD;
                        end
                    end
                    A_UNREADY: begin
                        if (!w_used) begin
                            n_status = ST_UNUSED;
                            n_state  = S_DONE;
                        end else if (!i_thr_sts.rdy_tid) begin
                            n_status = ST_IGNORED;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_PRIO_RD;
                        end
                    end
                    A_SETP: begin
                        if (!w_used) begin
                            n_status = ST_UNUSED;
                            n_state  = S_DONE;
                        end else if (i_thr_sts.rdy_tid) begin
                            n_status = ST_READY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_PRIO_RD;
                        end
                    end
                    default: begin
                        n_status = ST_IGNORED;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_act == A_CREATE) begin
                    // step through slots for the lowest free one
                    o_thr_cmd.rd_addr = r_idx;
                    if (!i_thr_sts.use_rd) begin
                        o_thr_cmd.tid       = r_idx;
                        o_thr_cmd.use_set   = 1'b1;
                        o_thr_cmd.prio_we   = 1'b1;
                        o_thr_cmd.prio_data = f_clamp(r_preq, LAST_P);
                        n_tid   = r_idx;
                        n_q     = f_clamp(r_preq, LAST_P);
                        n_tout  = r_idx;
                        n_state = S_QRD;
                    end else if (r_idx == LAST_T) begin
                        n_status = ST_NO_SLOT;
                        n_state  = S_DONE;
                    end else begin
                        n_idx = r_idx + t_id'(1);
                    end
                end else begin
                    // step through queues, highest priority first
                    o_q_cmd.addr = r_idx;
                    if (i_q_sts.head_v) begin
                        n_state = S_SCHED_OUT;
                    end else if (r_idx == LAST_P) begin
                        n_status = ST_NONE_READY;
                        n_state  = S_DONE;
                    end else begin
                        n_idx = r_idx + t_id'(1);
                    end
                end
            end
            S_PRIO_RD: begin
                n_q     = i_thr_sts.prio_q;
                n_tnext = i_thr_sts.link_q;
                n_tnvld = i_thr_sts.link_vld_q;
                if (r_act == A_SETP) begin
                    n_oldp = i_thr_sts.prio_q;
                    if (!r_preq[4]) begin
                        o_thr_cmd.prio_we   = 1'b1;
                        o_thr_cmd.prio_data = f_clamp(r_preq, LAST_P);
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                case (r_act)
                    A_UNREADY: n_state = S_UNRDY;
                    A_EXIT:    n_state = S_WALK;
                    default:   n_state = S_APPEND;
                endcase
            end
            S_APPEND: begin
                if (i_q_sts.tail_v) begin
                    o_thr_cmd.link_we   = 1'b1;
                    o_thr_cmd.link_addr = i_q_sts.tail_q;
                    o_thr_cmd.link_data = r_tid;
                    o_thr_cmd.link_vld  = 1'b1;
                end else begin
                    o_q_cmd.head_we   = 1'b1;
                    o_q_cmd.head_data = r_tid;
                    o_q_cmd.head_vld  = 1'b1;
                end
                o_q_cmd.tail_we   = 1'b1;
                o_q_cmd.tail_data = r_tid;
                o_q_cmd.tail_vld  = 1'b1;
                o_thr_cmd.nv_clr  = 1'b1;
                o_thr_cmd.rdy_set = 1'b1;
                n_state = S_DONE;
            end
            S_UNRDY: begin
                if (!i_q_sts.head_v || i_q_sts.head_q != r_tid) begin
                    n_status = ST_NOT_HEAD;
                end else begin
                    o_q_cmd.head_we   = 1'b1;
                    o_q_cmd.head_data = r_tnext;
                    o_q_cmd.head_vld  = r_tnvld;
                    if (!r_tnvld) begin
                        o_q_cmd.tail_we  = 1'b1;
                        o_q_cmd.tail_vld = 1'b0;
                    end
                    o_thr_cmd.nv_clr  = 1'b1;
                    o_thr_cmd.rdy_clr = 1'b1;
                end
                n_state = S_DONE;
            end
            S_WALK: begin
                if (!i_q_sts.head_v) begin
                    n_state = S_EXIT_CLR;
                end else begin
                    n_cur       = i_q_sts.head_q;
                    n_have_prev = 1'b0;
                    n_idx       = '0;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (r_cur == r_tid) begin
                    // splice the slot out between prev and its successor
                    if (r_have_prev) begin
                        o_thr_cmd.link_we   = 1'b1;
                        o_thr_cmd.link_addr = r_prev;
                        o_thr_cmd.link_data = r_tnext;
                        o_thr_cmd.link_vld  = r_tnvld;
                    end else begin
                        o_q_cmd.head_we   = 1'b1;
                        o_q_cmd.head_data = r_tnext;
                        o_q_cmd.head_vld  = r_tnvld;
                    end
                    if (!r_tnvld) begin
                        o_q_cmd.tail_we   = 1'b1;
                        o_q_cmd.tail_data = r_prev;
                        o_q_cmd.tail_vld  = r_have_prev;
                    end
                    n_state = S_EXIT_CLR;
                end else begin
                    o_thr_cmd.rd_addr = r_cur;
                    n_state = S_LINK_RD;
                end
            end
            S_LINK_RD: begin
                if (!i_thr_sts.link_vld_q || r_idx == LAST_T) begin
                    n_state = S_EXIT_CLR;
                end else begin
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_cur       = i_thr_sts.link_q;
                    n_idx       = r_idx + t_id'(1);
                    n_state     = S_CMP;
                end
            end
            S_EXIT_CLR: begin
                o_thr_cmd.use_clr = 1'b1;
                o_thr_cmd.rdy_clr = 1'b1;
                o_thr_cmd.nv_clr  = 1'b1;
                n_state = S_DONE;
            end
            S_SCHED_OUT: begin
                n_tout  = i_q_sts.head_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy       = r_state != S_IDLE;
    assign o_res.status = r_status;
    assign o_res.tout   = r_tout;
    assign o_res.oldp   = r_oldp;

    `ASSERT_IMPL(a_idle_after_done, i_clk, i_rst_n, $past(i_rst_n) && r_state == S_IDLE && $past(r_state) != S_IDLE, $past(r_state) == S_DONE, "left an action without a result")
    `ASSERT_NEXT(a_check_after_accept, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid, r_state == S_CHECK, "accepted item not checked")

endmodule

FILE: test/priority_ready_queue_scheduler_tb.sv
// Self-checking testbench for the ready-queue scheduler: result tracker class, drivers, checks.
`timescale 1ns / 1ps

import prqs_pkg::*;

localparam int N_THREADS = 8;
localparam int N_PRIOS   = 16;

// Action codes that the block does not define
localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

typedef enum int {
    PICK_USED,
    PICK_IDLE,
    PICK_QUEUED,
    PICK_HEAD
} t_pick;

typedef struct {
    logic [2:0] status;
    logic [2:0] tout;
    logic [3:0] oldp;
    longint     stamp;
    int         seq;
} t_sched_result;

class ready_queue_board;
    bit            in_use[N_THREADS];
    bit            rdy[N_THREADS];
    logic [3:0]    prio[N_THREADS];
    logic [2:0]    nxt[N_THREADS];
    bit            nxt_v[N_THREADS];
    logic [2:0]    head[N_PRIOS];
    bit            head_v[N_PRIOS];
    logic [2:0]    tail[N_PRIOS];
    bit            tail_v[N_PRIOS];
    t_sched_result pending[$];
    int            errors;
    int            checked;
    int            items;
    int            action_count[8];
    int            status_seen[8];

    function new();
        for (int i = 0; i < N_THREADS; i++) begin
            in_use[i] = 1'b0;
            rdy[i]    = 1'b0;
            prio[i]   = '0;
            nxt[i]    = '0;
            nxt_v[i]  = 1'b0;
        end
        for (int q = 0; q < N_PRIOS; q++) begin
            head[q]   = '0;
            head_v[q] = 1'b0;
            tail[q]   = '0;
            tail_v[q] = 1'b0;
        end
        errors  = 0;
        checked = 0;
        items   = 0;
        for (int i = 0; i < 8; i++) begin
            action_count[i] = 0;
            status_seen[i]  = 0;
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    function logic [3:0] clip_prio(logic signed [4:0] p);
        if (p < 0) begin
            return 4'd0;
        end
        if (p >= N_PRIOS) begin
            return 4'(N_PRIOS - 1);
        end
        return p[3:0];
    endfunction

    function void enqueue(logic [2:0] t);
        logic [3:0] q;
        q = prio[t];
        if (tail_v[q]) begin
            nxt[tail[q]]   = t;
            nxt_v[tail[q]] = 1'b1;
        end else begin
            head[q]   = t;
            head_v[q] = 1'b1;
        end
        tail[q]   = t;
        tail_v[q] = 1'b1;
        nxt[t]    = '0;
        nxt_v[t]  = 1'b0;
        rdy[t]    = 1'b1;
    endfunction

    // Walk the queue of t and splice it out wherever it sits.
    function void unlink(logic [2:0] t);
        logic [3:0] q;
        logic [2:0] prev;
        logic [2:0] cur;
        bit         have_prev;
        q         = prio[t];
        prev      = '0;
        have_prev = 1'b0;
        if (!head_v[q]) begin
            return;
        end
        cur = head[q];
        for (int g = 0; g < N_THREADS; g++) begin
            if (cur == t) begin
                if (have_prev) begin
                    nxt[prev]   = nxt[t];
                    nxt_v[prev] = nxt_v[t];
                end else begin
                    head[q]   = nxt[t];
                    head_v[q] = nxt_v[t];
                end
                if (!nxt_v[t]) begin
                    tail[q]   = prev;
                    tail_v[q] = have_prev;
                end
                break;
            end
            if (!nxt_v[cur]) begin
                break;
            end
            prev      = cur;
            have_prev = 1'b1;
            cur       = nxt[cur];
        end
        nxt[t]   = '0;
        nxt_v[t] = 1'b0;
        rdy[t]   = 1'b0;
    endfunction

    function void note_item(logic [2:0] act, logic [2:0] tid, logic signed [4:0] preq,
                            longint now);
        t_sched_result r;
        bit            used;
        logic [3:0]    q;
        r.status = ST_OK;
        r.tout   = '0;
        r.oldp   = '0;
        r.stamp  = now;
        r.seq    = items;
        used     = in_use[tid];
        items++;
        action_count[act]++;
        case (act)
            A_CREATE: begin
                r.status = ST_NO_SLOT;
                for (int i = 0; i < N_THREADS; i++) begin
                    if (!in_use[i]) begin
                        in_use[i] = 1'b1;
                        rdy[i]    = 1'b0;
                        prio[i]   = clip_prio(preq);
                        enqueue(3'(i));
                        r.status  = ST_OK;
                        r.tout    = 3'(i);
                        break;
                    end
                end
            end
            A_EXIT: begin
                if (!used) begin
                    r.status = ST_UNUSED;
                end else begin
                    if (rdy[tid]) begin
                        unlink(tid);
                    end
                    in_use[tid] = 1'b0;
                    rdy[tid]    = 1'b0;
                    prio[tid]   = '0;
                    nxt[tid]    = '0;
                    nxt_v[tid]  = 1'b0;
                end
            end
            A_READY: begin
                if (!used) begin
                    r.status = ST_UNUSED;
                end else if (rdy[tid]) begin
                    r.status = ST_IGNORED;
                end else begin
                    enqueue(tid);
                end
            end
            A_UNREADY: begin
                q = prio[tid];
                if (!used) begin
                    r.status = ST_UNUSED;
                end else if (!rdy[tid]) begin
                    r.status = ST_IGNORED;
                end else if (!head_v[q] || head[q] != tid) begin
                    r.status = ST_NOT_HEAD;
                end else begin
                    head[q]   = nxt[tid];
                    head_v[q] = nxt_v[tid];
                    if (!head_v[q]) begin
                        tail_v[q] = 1'b0;
                        tail[q]   = '0;
                    end
                    nxt[tid]   = '0;
                    nxt_v[tid] = 1'b0;
                    rdy[tid]   = 1'b0;
                end
            end
            A_SETP: begin
                if (!used) begin
                    r.status = ST_UNUSED;
                end else if (rdy[tid]) begin
                    r.status = ST_READY;
                end else begin
                    r.oldp = prio[tid];
                    if (preq >= 0) begin
                        prio[tid] = clip_prio(preq);
                    end
                end
            end
            A_SCHED: begin
                r.status = ST_NONE_READY;
                for (int i = 0; i < N_PRIOS; i++) begin
                    if (head_v[i]) begin
                        r.status = ST_OK;
                        r.tout   = head[i];
                        break;
                    end
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        pending.push_back(r);
    endfunction

    task check_result(logic [2:0] st, logic [2:0] tout, logic [3:0] oldp, longint now);
        t_sched_result due;
        // An item taken in this same step cannot have its result yet
        if (pending.size() == 0 || pending[0].stamp == now) begin
            report($sformatf("result status %0d thread %0d with no item outstanding",
                             st, tout));
            return;
        end
        due = pending.pop_front();
        checked++;
        status_seen[due.status]++;
        if (st !== due.status) begin
            report($sformatf("item %0d: status %0d, want %0d", due.seq, st, due.status));
        end
        if (tout !== due.tout) begin
            report($sformatf("item %0d: thread_out %0d, want %0d", due.seq, tout, due.tout));
        end
        if (oldp !== due.oldp) begin
            report($sformatf("item %0d: old_priority %0d, want %0d", due.seq, oldp,
                             due.oldp));
        end
    endtask

    function int pick_slot(t_pick kind);
        int cand[$];
        for (int i = 0; i < N_THREADS; i++) begin
            case (kind)
                PICK_USED:   if (in_use[i]) cand.push_back(i);
                PICK_IDLE:   if (in_use[i] && !rdy[i]) cand.push_back(i);
                PICK_QUEUED: if (in_use[i] && rdy[i]) cand.push_back(i);
                PICK_HEAD: begin
                    if (in_use[i] && rdy[i] && head_v[prio[i]] && head[prio[i]] == i) begin
                        cand.push_back(i);
                    end
                end
                default: ;
            endcase
        end
        if (cand.size() == 0) begin
            return -1;
        end
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction
endclass

module priority_ready_queue_scheduler_tb;

    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [2:0]        i_action;
    logic [2:0]        i_thread_id;
    logic signed [4:0] i_priority_req;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [2:0]        o_status;
    logic [2:0]        o_thread_out;
    logic [3:0]        o_old_priority;

    ready_queue_board board = new();

    bit  calm = 1'b0;
    int  calm_left = 0;
    int  stall_left = 0;
    int  cycle_count = 0;

    priority_ready_queue_scheduler #(
        .THREADS    (N_THREADS),
        .PRIORITIES (N_PRIOS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_thread_out   (o_thread_out),
        .o_old_priority (o_old_priority)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short runs, now and then a long one
    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    function automatic int idle_len();
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return burst_len();
    endfunction

    function automatic logic signed [4:0] rand_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 5'($urandom_range(0, 3));
        end
        if (r < 80) begin
            return 5'($urandom_range(0, 15));
        end
        return 5'($urandom);
    endfunction

    // Aim most slot actions at slots where they do real work
    function automatic void pick_item(output logic [2:0] act, output logic [2:0] tid,
                                      output logic signed [4:0] preq);
        int    r;
        int    slot;
        bit    aim;
        t_pick want;
        r    = $urandom_range(0, 99);
        tid  = 3'($urandom_range(0, 7));
        preq = rand_prio();
        aim  = 1'b0;
        want = PICK_USED;
        if (r < 3) begin
            act = $urandom_range(0, 1) ? ACT_UNDEF_LO : ACT_UNDEF_HI;
        end else if (r < 20) begin
            act = A_CREATE;
        end else if (r < 33) begin
            act = A_EXIT;
            aim = 1'b1;
        end else if (r < 50) begin
            act  = A_READY;
            aim  = 1'b1;
            want = PICK_IDLE;
        end else if (r < 67) begin
            act  = A_UNREADY;
            aim  = 1'b1;
            want = ($urandom_range(0, 3) != 0) ? PICK_HEAD : PICK_QUEUED;
        end else if (r < 81) begin
            act  = A_SETP;
            aim  = 1'b1;
            want = PICK_IDLE;
        end else begin
            act = A_SCHED;
        end
        if (aim && $urandom_range(0, 9) < 8) begin
            slot = board.pick_slot(want);
            if (slot >= 0) begin
                tid = 3'(slot);
            end
        end
    endfunction

    task automatic send_item(logic [2:0] act, logic [2:0] tid, logic signed [4:0] preq,
                             int gap);
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_thread_id    <= tid;
        i_priority_req <= preq;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        board.note_item(act, tid, preq, $time);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Alternate stretches of no idling with stretches of random idling
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 400);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_status, o_thread_out, o_old_priority, $time);
        end
        if (stall_left == 0) begin
            if (!calm && !i_out_stall && $urandom_range(0, 1) == 0) begin
                i_out_stall <= 1'b1;
                stall_left  = burst_len();
            end else begin
                i_out_stall <= 1'b0;
                stall_left  = $urandom_range(1, 8);
            end
        end else begin
            stall_left--;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles without finishing", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [2:0]        act;
        logic [2:0]        tid;
        logic signed [4:0] preq;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_action       <= '0;
        i_thread_id    <= '0;
        i_priority_req <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, unused slots, queue order and refusals
        send_item(A_SCHED, 3'd0, 5'sd0, idle_len());
        send_item(A_EXIT, 3'd7, 5'sd0, idle_len());
        send_item(A_READY, 3'd3, 5'sd0, idle_len());
        send_item(A_CREATE, 3'd0, 5'sd15, idle_len());
        send_item(A_CREATE, 3'd5, -5'sd1, idle_len());
        send_item(A_CREATE, 3'd7, 5'sb10000, idle_len());
        send_item(A_SCHED, 3'd7, 5'sd0, idle_len());
        send_item(A_UNREADY, 3'd2, 5'sd0, idle_len());
        send_item(A_SETP, 3'd1, 5'sd4, idle_len());
        send_item(A_UNREADY, 3'd1, 5'sd0, idle_len());
        send_item(A_UNREADY, 3'd1, 5'sd0, idle_len());
        send_item(A_SETP, 3'd1, -5'sd1, idle_len());
        send_item(A_SETP, 3'd1, 5'sd7, idle_len());
        send_item(A_READY, 3'd1, 5'sd0, idle_len());
        send_item(A_READY, 3'd1, 5'sd0, idle_len());
        send_item(ACT_UNDEF_LO, 3'd0, 5'sd0, idle_len());
        send_item(ACT_UNDEF_HI, 3'd7, 5'sd15, idle_len());
        // Fill the table, then overflow it
        repeat (6) send_item(A_CREATE, 3'd0, 5'sd3, idle_len());
        send_item(A_EXIT, 3'd4, 5'sd0, idle_len());
        send_item(A_SCHED, 3'd0, 5'sd0, idle_len());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick_item(act, tid, preq);
            send_item(act, tid, preq, idle_len());
        end
        i_in_valid <= 1'b0;

        while (board.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items:", board.items,
                 " create %0d, exit %0d, make ready %0d,", board.action_count[A_CREATE],
                 board.action_count[A_EXIT], board.action_count[A_READY],
                 " unready %0d, set prio %0d, schedule %0d,", board.action_count[A_UNREADY],
                 board.action_count[A_SETP], board.action_count[A_SCHED],
                 " undefined %0d",
                 board.action_count[ACT_UNDEF_LO] + board.action_count[ACT_UNDEF_HI]);
        $display("Checked %0d results:", board.checked,
                 " ok %0d, ignored %0d, no slot %0d,", board.status_seen[ST_OK],
                 board.status_seen[ST_IGNORED], board.status_seen[ST_NO_SLOT],
                 " none ready %0d, not head %0d,", board.status_seen[ST_NONE_READY],
                 board.status_seen[ST_NOT_HEAD],
                 " unused %0d, ready %0d", board.status_seen[ST_UNUSED],
                 board.status_seen[ST_READY]);
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
